/* rtl/fp8dq_pkg.sv */
// shared types and constants for the fp8 e4m3 scaled dequantizer
// no dependencies
package fp8dq_pkg;

    localparam logic [15:0] BF16_QNAN = 16'h7FC0;
    localparam logic [15:0] BF16_INF  = 16'h7F80;
    localparam logic [7:0]  F32_EXP_MAX = 8'hFF;

    typedef struct packed {
        logic        sign;
        logic        nan;
        logic        inf;
        logic        zero;
        logic [10:0] prod;   // 4-bit code significand times low part
    } t_dq_flags;

endpackage

/* rtl/fp8dq_round.sv */
// fp32 rounding of the exact product, then bf16 rounding
// depends on fp8dq_pkg
module fp8dq_round
    import fp8dq_pkg::*;
(
    input  logic [27:0] i_prod,
    input  logic [9:0]  i_exp,
    output logic [14:0] o_mag
);
    logic [4:0]         lz;
    logic [27:0]        norm;
    logic signed [11:0] bexp;
    logic [5:0]         sh;
    logic [52:0]        wide;
    logic [52:0]        shd;
    logic               g;
    logic               st;
    logic [24:0]        q;
    logic [31:0]        f;
    logic [16:0]        r;

    always_comb begin
        lz = 5'd0;
        for (int k = 0; k < 28; k++) begin
            if (i_prod[k]) begin
                lz = 5'(27 - k);
            end
        end
        norm = i_prod << lz;
        // value = norm[27].norm[26:0] * 2^(exp - lz), exp is two's complement
        bexp = $signed({{2{i_exp[9]}}, i_exp}) - $signed({7'd0, lz});
        if (bexp < 12'sd1) begin
            sh = (bexp < -12'sd40) ? 6'd41 : 6'(12'sd1 - bexp);
        end else begin
            sh = 6'd0;
        end
        wide = {norm, 25'd0} >> sh;
        shd = wide;
        q = {1'b0, shd[52:29]};
        g = shd[28];
        st = |shd[27:0];
        if (g && (st || q[0])) begin
            q = q + 25'd1;
        end
        if (bexp < 12'sd1) begin
            f = {8'd0, q[23:0]};
            if (q[23]) begin
                f = {9'd0, 23'(q[22:0])} | 32'h0080_0000;
            end
        end else if (q[24]) begin
            f = (bexp + 12'sd1 >= 12'sd255) ? 32'h7F80_0000 :
                {1'b0, 8'(bexp + 12'sd1), 23'd0};
        end else begin
            f = (bexp >= 12'sd255) ? 32'h7F80_0000 : {1'b0, 8'(bexp), q[22:0]};
        end
        if (f == 32'h7F80_0000) begin
            o_mag = BF16_INF[14:0];
            r = 17'd0;
        end else begin
            r = 17'((33'(f) + 33'h7FFF + 33'(f[16])) >> 16);
            o_mag = r[14:0];
        end
    end
endmodule

/* rtl/fp8_e4m3_scaled_dequant_bf16.sv */
// top level: fp8 e4m3 code times fp32 scale, rounded to bf16
// depends on fp8dq_pkg and fp8dq_round
// One request enters per cycle unless stalled; its bf16 result appears in the cycle
// after acceptance; throughput is one element per clock, set by one registered pass
// through decode, 4x24 multiply and rounding, with one output register between sides.
module fp8_e4m3_scaled_dequant_bf16
    import fp8dq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_fp8_code,
    input  logic [31:0] i_scale_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_bf16_value
);
    logic        r_valid, n_valid;
    logic [15:0] r_data, n_data;
    logic        acc;
    logic [3:0]  e8;
    logic [2:0]  m8;
    logic [7:0]  se;
    logic [22:0] sm;
    logic        sign;
    logic [3:0]  a;
    logic [23:0] b;
    logic [27:0] prod;
    logic [9:0]  ex;
    logic [14:0] mag;
    logic [15:0] res;

    assign o_ready = !r_valid || i_ready;
    assign acc     = i_valid && o_ready;

    always_comb begin
        e8   = i_fp8_code[6:3];
        m8   = i_fp8_code[2:0];
        se   = i_scale_bits[30:23];
        sm   = i_scale_bits[22:0];
        sign = i_fp8_code[7] ^ i_scale_bits[31];
        a    = (e8 == 4'd0) ? {1'b0, m8} : {1'b1, m8};
        b    = (se == 8'd0) ? {1'b0, sm} : {1'b1, sm};
        prod = 28'(a) * 28'(b);
        // biased fp32 exponent of prod bit 27 position: ea+eb+27+127
        ex   = 10'(((e8 == 4'd0) ? 10'd1 : 10'(e8)) + ((se == 8'd0) ? 10'd1 : 10'(se)) - 10'd6);
    end

    fp8dq_round u_round (
        .i_prod (prod),
        .i_exp  (ex),
        .o_mag  (mag)
    );

    always_comb begin
        if ((e8 == 4'hF && m8 == 3'd7) || (se == F32_EXP_MAX && sm != '0)) begin
            res = BF16_QNAN;
        end else if (se == F32_EXP_MAX) begin
            res = (a == '0) ? BF16_QNAN : {sign, BF16_INF[14:0]};
        end else if (a == '0 || b == '0) begin
            res = {sign, 15'd0};
        end else begin
            res = {sign, mag};
        end
        n_valid = acc ? 1'b1 : (i_ready ? 1'b0 : r_valid);
        n_data  = acc ? res : r_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_valid      = r_valid;
    assign o_bf16_value = r_data;

`ifndef ASSERT_OFF
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> o_valid) else $error("accepted request not shown");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bf16_value)) else $error("result lost");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("stalled while empty");
`endif
endmodule

/* sim/fp8_e4m3_scaled_dequant_bf16_tb.sv */
// testbench for fp8_e4m3_scaled_dequant_bf16: directed and random e4m3 codes and fp32 scales,
// each bf16 result checked against an in-bench integer model of decode, fp32 and bf16 rounding
// depends on fp8dq_pkg and the rtl top level
module fp8_e4m3_scaled_dequant_bf16_tb
    import fp8dq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_fp8_code;
    logic [31:0] i_scale_bits;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_bf16_value;

    logic [15:0] bf16_expected_q[$];
    int          mismatch_count;
    int          hold_off_cycles;

    fp8_e4m3_scaled_dequant_bf16 u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_fp8_code   (i_fp8_code),
        .i_scale_bits (i_scale_bits),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_bf16_value (o_bf16_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [63:0] rne_shift(logic [63:0] v, int s);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (s == 0) return v;
        if (s >= 63) return 64'd0;
        q = v >> s;
        rem = v & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        return q;
    endfunction

    function automatic logic [31:0] f32_magnitude(logic [63:0] p, int e);
        int n;
        int t;
        int sh;
        logic [63:0] q;
        n = 63;
        while (n > 0 && !p[n]) n--;
        t = n + e - 23;
        if (t < -149) t = -149;
        sh = t - e;
        if (sh > 0) q = rne_shift(p, sh);
        else q = p << (-sh);
        if (q >= (64'd1 << 24)) begin
            q = q >> 1;
            t++;
        end
        if (q < (64'd1 << 23)) return q[31:0];
        if (t + 150 >= 255) return 32'h7F80_0000;
        return {t[8:0] + 9'd150, q[22:0]} & 32'h7FFF_FFFF;
    endfunction

    function automatic logic [15:0] dequant_bf16(logic [7:0] code, logic [31:0] scale);
        logic        sgn;
        logic [3:0]  e8;
        logic [2:0]  m8;
        logic [7:0]  se;
        logic [22:0] sm;
        logic [63:0] a;
        logic [63:0] b;
        int          ea;
        int          eb;
        logic [31:0] f;
        logic [31:0] r;
        sgn = code[7] ^ scale[31];
        e8 = code[6:3];
        m8 = code[2:0];
        se = scale[30:23];
        sm = scale[22:0];
        if ((e8 == 4'hF && m8 == 3'h7) || (se == F32_EXP_MAX && sm != 0)) return BF16_QNAN;
        if (e8 == 0) begin
            a = 64'(m8);
            ea = -9;
        end else begin
            a = 64'({1'b1, m8});
            ea = int'(e8) - 10;
        end
        if (se == F32_EXP_MAX) begin
            if (a == 0) return BF16_QNAN;
            return {sgn, 15'h0000} | BF16_INF;
        end
        if (se == 0) begin
            b = 64'(sm);
            eb = -149;
        end else begin
            b = 64'({1'b1, sm});
            eb = int'(se) - 150;
        end
        if (a == 0 || b == 0) return {sgn, 15'h0000};
        f = f32_magnitude(a * b, ea + eb);
        if (f == 32'h7F80_0000) r = 32'h7F80;
        else r = (f + 32'h7FFF + {31'd0, f[16]}) >> 16;
        return {sgn, r[14:0]};
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic send_request(logic [7:0] code, logic [31:0] scale, bit idle_gaps);
        int gap;
        gap = idle_gaps ? gap_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_fp8_code <= code;
        i_scale_bits <= scale;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bf16_expected_q.push_back(dequant_bf16(code, scale));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (bf16_expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_scale();
        logic [31:0] s;
        s = $urandom();
        case ($urandom_range(0, 7))
            0: s[30:23] = 8'h00;
            1: s[30:23] = F32_EXP_MAX;
            2: s[30:23] = 8'($urandom_range(0, 12));
            3: s[30:23] = 8'($urandom_range(240, 254));
            4: s[30:0] = 31'd0;
            5: s[15:0] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: s[30:23] = 8'($urandom_range(100, 150));
        endcase
        return s;
    endfunction

    task automatic test_directed();
        logic [7:0]  codes[12] = '{8'h00, 8'h80, 8'h01, 8'h07, 8'h08, 8'h7E, 8'hFE,
                                   8'h7F, 8'hFF, 8'h38, 8'hB8, 8'h78};
        logic [31:0] scales[12] = '{32'h3F80_0000, 32'h7F80_0000, 32'hFF80_0000,
                                    32'h7FC0_0001, 32'h0000_0000, 32'h8000_0000,
                                    32'h0000_0001, 32'h7F7F_FFFF, 32'h0080_0000,
                                    32'h3F80_8000, 32'h3F81_8000, 32'hFFFF_FFFF};
        for (int k = 0; k < 24; k++)
            send_request(codes[k % 12], scales[(k * 5) % 12], 1'b0);
        send_request(8'h00, 32'h7F80_0000, 1'b0);
        wait_drained();
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++)
            send_request(8'($urandom_range(0, 255)), random_scale(), 1'b1);
    endtask

    task automatic test_back_pressure();
        hold_off_cycles = 60;
        for (int k = 0; k < 40; k++)
            send_request(8'($urandom_range(0, 255)), random_scale(), 1'b0);
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_fp8_code = '0;
        i_scale_bits = '0;
        mismatch_count = 0;
        hold_off_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(700);
        wait_drained();
        test_back_pressure();
        test_random(760);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end
            stall = gap_length();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        logic [15:0] exp_val;
        if (i_rst_n && o_valid && i_ready) begin
            if (bf16_expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_bf16_value);
                mismatch_count++;
            end else begin
                exp_val = bf16_expected_q.pop_front();
                if (o_bf16_value !== exp_val) begin
                    $display("%0t: bf16 mismatch, expected %h, actual %h",
                             $time, exp_val, o_bf16_value);
                    mismatch_count++;
                end
            end
        end
    end
endmodule

/* fp8_e4m3_scaled_dequant_bf16.f */
rtl/fp8dq_pkg.sv
rtl/fp8dq_round.sv
rtl/fp8_e4m3_scaled_dequant_bf16.sv
sim/fp8_e4m3_scaled_dequant_bf16_tb.sv
